// File: hw/rtl/rbsi_pkg.sv
// Shared types and constants for the ray against box slab test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rbsi_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int WORD_W        = 32;                   // fixed-point word
   localparam int MAG_W         = 32;                   // magnitude of a difference or a direction
   localparam int QUO_W         = MAG_W + FRACTION_BITS; // unsigned quotient width
   localparam int T_W           = QUO_W + 1;            // signed distance width
   localparam int ENTRY_W       = 31;
   localparam int LANE_LAT      = QUO_W + 2;            // lane latency in cycles
   localparam int PIPE_LAT      = LANE_LAT + 2;         // request to response

   localparam logic [2:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [2:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [2:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [2:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [2:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [2:0] CSR_BOX_MAX_Z = 3'd5;

   localparam logic signed [WORD_W-1:0] BOX_MIN_RESET = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] BOX_MAX_RESET = 32'sh8000_0000;

   localparam logic signed [T_W-1:0] T_TOP = {1'b0, {(T_W-1){1'b1}}};
   localparam logic signed [T_W-1:0] ENTRY_MAX_T =
      T_W'({1'b0, {ENTRY_W{1'b1}}});

   // What one lane reports for its axis.
   typedef struct packed {
      logic                   miss;
      logic signed [T_W-1:0]  t_near;
      logic signed [T_W-1:0]  t_far;
   } lane_res_type;

   typedef struct packed {
      logic neg_lo;
      logic neg_hi;
      logic dir_zero;
      logic par_miss;
   } lane_side_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] nq;
      logic [MAG_W-1:0] den;
   } div_stage_type;

endpackage

// File: hw/rtl/rbsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, for unsigned magnitudes.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_div import rbsi_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [MAG_W-1:0] num_mag,
   input  logic [MAG_W-1:0] den_mag,
   output logic [QUO_W-1:0] quo
);

   div_stage_type st_ff [QUO_W];
   div_stage_type st_in [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      div_stage_type prev;
      logic [MAG_W:0] cand;
      logic           take;

      always_comb begin
         if (i == 0) begin
            prev.rem = '0;
            prev.nq  = {num_mag, {FRACTION_BITS{1'b0}}};
            prev.den = den_mag;
         end else begin
            prev = st_ff[(i == 0) ? 0 : i - 1];
         end
         // Bring down the next numerator bit and try the subtraction.
         cand = {prev.rem, prev.nq[QUO_W-1]};
         take = (cand >= {1'b0, prev.den});
         st_in[i].rem = take ? MAG_W'(cand - {1'b0, prev.den}) : cand[MAG_W-1:0];
         st_in[i].nq  = {prev.nq[QUO_W-2:0], take};
         st_in[i].den = prev.den;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign quo = st_ff[QUO_W-1].nq;

endmodule

// File: hw/rtl/rbsi_lane.sv
// One axis of the slab test: differences, two pipelined divisions and ordering.
// Depends on rbsi_pkg and rbsi_div.
`timescale 1ns / 1ps

module rbsi_lane import rbsi_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [WORD_W-1:0] box_lo,
   input  logic signed [WORD_W-1:0] box_hi,
   input  logic signed [WORD_W-1:0] origin,
   input  logic signed [WORD_W-1:0] dir,
   output lane_res_type             res
);

   logic signed [WORD_W:0] diff_lo, diff_hi;
   logic [MAG_W-1:0]       mag_lo_ff, mag_hi_ff, den_ff;
   lane_side_type          side_in, side_ff;
   lane_side_type          side_pipe_ff [QUO_W];
   logic [QUO_W-1:0]       q_lo, q_hi;
   logic signed [T_W-1:0]  t_a, t_b;
   lane_res_type           res_in, res_ff;

   assign diff_lo = $signed({box_lo[WORD_W-1], box_lo}) -
                    $signed({origin[WORD_W-1], origin});
   assign diff_hi = $signed({box_hi[WORD_W-1], box_hi}) -
                    $signed({origin[WORD_W-1], origin});

   always_comb begin
      side_in.neg_lo   = diff_lo[WORD_W] ^ dir[WORD_W-1];
      side_in.neg_hi   = diff_hi[WORD_W] ^ dir[WORD_W-1];
      side_in.dir_zero = (dir == '0);
      side_in.par_miss = (dir == '0) && ((origin < box_lo) || (origin > box_hi));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_lo_ff <= diff_lo[WORD_W] ? MAG_W'(-diff_lo) : MAG_W'(diff_lo);
         mag_hi_ff <= diff_hi[WORD_W] ? MAG_W'(-diff_hi) : MAG_W'(diff_hi);
         den_ff    <= dir[WORD_W-1] ? MAG_W'(-{dir[WORD_W-1], dir})
                                    : MAG_W'({1'b0, dir});
         side_ff   <= side_in;
      end
   end

   rbsi_div u_div_lo (
      .clock   (clock),
      .en      (en),
      .num_mag (mag_lo_ff),
      .den_mag (den_ff),
      .quo     (q_lo)
   );

   rbsi_div u_div_hi (
      .clock   (clock),
      .en      (en),
      .num_mag (mag_hi_ff),
      .den_mag (den_ff),
      .quo     (q_hi)
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_pipe_ff[i] <= (i == 0) ? side_ff : side_pipe_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_comb begin
      t_a = side_pipe_ff[QUO_W-1].neg_lo ? -$signed({1'b0, q_lo}) : $signed({1'b0, q_lo});
      t_b = side_pipe_ff[QUO_W-1].neg_hi ? -$signed({1'b0, q_hi}) : $signed({1'b0, q_hi});
      res_in.miss = side_pipe_ff[QUO_W-1].par_miss;
      if (side_pipe_ff[QUO_W-1].dir_zero) begin
         // A parallel axis leaves the interval as it is.
         res_in.t_near = '0;
         res_in.t_far  = T_TOP;
      end else if (t_a > t_b) begin
         res_in.t_near = t_b;
         res_in.t_far  = t_a;
      end else begin
         res_in.t_near = t_a;
         res_in.t_far  = t_b;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: hw/rtl/rbsi_merge.sv
// Merges the three lane results into the final interval, hit flag and entry distance.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_merge import rbsi_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  lane_res_type       lane_x,
   input  lane_res_type       lane_y,
   input  lane_res_type       lane_z,
   output logic               hit,
   output logic [ENTRY_W-1:0] entry_distance
);

   logic signed [T_W-1:0] near_xy, near_in, far_xy, far_in;
   logic signed [T_W-1:0] near_ff, far_ff;
   logic                  miss_ff;

   always_comb begin
      near_xy = (lane_x.t_near > lane_y.t_near) ? lane_x.t_near : lane_y.t_near;
      near_in = (lane_z.t_near > near_xy) ? lane_z.t_near : near_xy;
      if (near_in < 0) begin
         near_in = '0;
      end
      far_xy = (lane_x.t_far < lane_y.t_far) ? lane_x.t_far : lane_y.t_far;
      far_in = (lane_z.t_far < far_xy) ? lane_z.t_far : far_xy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         near_ff <= near_in;
         far_ff  <= far_in;
         miss_ff <= lane_x.miss | lane_y.miss | lane_z.miss;
      end
   end

   always_comb begin
      hit = !miss_ff && !(near_ff > far_ff);
      if (!hit) begin
         entry_distance = '0;
      end else if (near_ff > ENTRY_MAX_T) begin
         entry_distance = {ENTRY_W{1'b1}};
      end else begin
         entry_distance = near_ff[ENTRY_W-1:0];
      end
   end

endmodule

// File: hw/rtl/ray_box_slab_intersect.sv
// Top level of the ray against axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_lane and rbsi_merge.
`timescale 1ns / 1ps

// The box is held in six registers written through the csr_ port (index 0 to 5:
// min x, y, z, then max x, y, z); writes to other indices are ignored. After
// reset every minimum is the largest value and every maximum the smallest, so
// a ray parallel to any axis misses until the bounds are written; on an axis
// with a nonzero direction the swapped bounds are simply put in order.
// Each request carries a ray origin and direction in signed Q16.16 and is
// accepted when req_valid is high and req_stall is low. Exactly one response
// follows for each request, in order, holding the hit flag and the entry
// distance (zero on a miss, saturated to the largest 31-bit value).
// Three lanes, one per axis, each run two pipelined restoring dividers that
// produce one quotient bit per stage; the 48 quotient bits set the depth.
// rsp_valid rises once a request has passed the lane, merge and output registers,
// and one request is taken every cycle while req_stall is low. The whole pipeline
// advances together: while a response is held by rsp_stall, the pipeline freezes
// and req_stall is raised, but bubbles in an otherwise stalled stream still let
// req_stall stay low whilst the output is empty. Reset is synchronous and clears
// the pipeline valid bits and the box registers; nothing else needs clearing.

module ray_box_slab_intersect import rbsi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [2:0]               csr_index,
   input  logic [WORD_W-1:0]        csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [WORD_W-1:0] req_ray_origin_x,
   input  logic signed [WORD_W-1:0] req_ray_origin_y,
   input  logic signed [WORD_W-1:0] req_ray_origin_z,
   input  logic signed [WORD_W-1:0] req_ray_dir_x,
   input  logic signed [WORD_W-1:0] req_ray_dir_y,
   input  logic signed [WORD_W-1:0] req_ray_dir_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [ENTRY_W-1:0]       rsp_entry_distance
);

   logic signed [WORD_W-1:0] box_min_x_ff, box_min_y_ff, box_min_z_ff;
   logic signed [WORD_W-1:0] box_max_x_ff, box_max_y_ff, box_max_z_ff;
   logic [PIPE_LAT-1:0]      vld_ff, vld_in;
   logic                     advance;
   lane_res_type             res_x, res_y, res_z;
   logic                     hit_c, hit_ff;
   logic [ENTRY_W-1:0]       entry_c, entry_ff;

   // Box registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= BOX_MIN_RESET;
         box_min_y_ff <= BOX_MIN_RESET;
         box_min_z_ff <= BOX_MIN_RESET;
         box_max_x_ff <= BOX_MAX_RESET;
         box_max_y_ff <= BOX_MAX_RESET;
         box_max_z_ff <= BOX_MAX_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: box_min_x_ff <= csr_data;
            CSR_BOX_MIN_Y: box_min_y_ff <= csr_data;
            CSR_BOX_MIN_Z: box_min_z_ff <= csr_data;
            CSR_BOX_MAX_X: box_max_x_ff <= csr_data;
            CSR_BOX_MAX_Y: box_max_y_ff <= csr_data;
            CSR_BOX_MAX_Z: box_max_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output slot is empty or being taken.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   assign vld_in = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   rbsi_lane u_lane_x (
      .clock  (clock),
      .en     (advance),
      .box_lo (box_min_x_ff),
      .box_hi (box_max_x_ff),
      .origin (req_ray_origin_x),
      .dir    (req_ray_dir_x),
      .res    (res_x)
   );

   rbsi_lane u_lane_y (
      .clock  (clock),
      .en     (advance),
      .box_lo (box_min_y_ff),
      .box_hi (box_max_y_ff),
      .origin (req_ray_origin_y),
      .dir    (req_ray_dir_y),
      .res    (res_y)
   );

   rbsi_lane u_lane_z (
      .clock  (clock),
      .en     (advance),
      .box_lo (box_min_z_ff),
      .box_hi (box_max_z_ff),
      .origin (req_ray_origin_z),
      .dir    (req_ray_dir_z),
      .res    (res_z)
   );

   rbsi_merge u_merge (
      .clock          (clock),
      .en             (advance),
      .lane_x         (res_x),
      .lane_y         (res_y),
      .lane_z         (res_z),
      .hit            (hit_c),
      .entry_distance (entry_c)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff   <= hit_c;
         entry_ff <= entry_c;
      end
   end

   assign rsp_valid          = vld_ff[PIPE_LAT-1];
   assign rsp_hit            = hit_ff;
   assign rsp_entry_distance = entry_ff;

endmodule
